// ===== rtl/fspa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Field widths, operation and status codes, register indexes and the
// divider request bundle shared by the allocator files.
// ----------------------------------------------------------------------------
package fspa_pkg;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned OFF_W      = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_OFF_W = 26;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned SIZE_RAW_W = 16;
  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned CNT_CFG_W  = 11;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  // Slot size rounding: add seven, clear the low three bits, floor at eight
  localparam int unsigned SIZE_ROUND_ADD = 7;
  localparam int unsigned SIZE_ALIGN_LSB = 3;
  localparam int unsigned MIN_SLOT_SIZE  = 8;

  localparam int unsigned SLOT_SIZE_RST  = 8;
  localparam int unsigned SLOT_COUNT_RST = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_INIT  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FREED = 3'd2,
    ST_OOB   = 3'd3,
    ST_FULL  = 3'd4,
    ST_INIT  = 3'd5
  } status_e;

  typedef struct packed {
    logic              start;
    logic [OFF_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/fspa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool allocator channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface fspa_req_if;
  logic                          valid;
  logic                          ready;
  logic [fspa_pkg::FUNC_W-1:0]   func;
  logic [fspa_pkg::OFF_W-1:0]    free_offset;

  modport source (output valid, func, free_offset, input ready);
  modport sink   (input valid, func, free_offset, output ready);
endinterface

interface fspa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [fspa_pkg::STATUS_W-1:0]   status;
  logic [fspa_pkg::SLOT_OFF_W-1:0] slot_offset;
  logic [fspa_pkg::IDX_W-1:0]      slot_index;

  modport source (output valid, status, slot_offset, slot_index, input ready);
  modport sink   (input valid, status, slot_offset, slot_index, output ready);
endinterface

// ===== rtl/fspa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fspa_ram #(
  parameter  int unsigned WIDTH  = 10,
  parameter  int unsigned DEPTH  = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fspa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot index divider
// Restoring division of a byte offset by the slot size, one quotient bit
// per cycle. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module fspa_div #(
  parameter int unsigned QW = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fspa_pkg::div_req_t req_i,
  output logic               done_o,
  output logic [QW-1:0]      quot_o
);
  import fspa_pkg::*;

  localparam int unsigned SD_W = SIZE_W + QW - 1;
  localparam int unsigned RW   = (SD_W > OFF_W) ? SD_W : OFF_W;
  localparam int unsigned STW  = $clog2(QW + 1);

  logic [RW-1:0]   rem_q, rem_d;
  logic [SD_W-1:0] sd_q, sd_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [STW-1:0]  steps_q, steps_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            ge;

  always_comb begin
    rem_d   = rem_q;
    sd_d    = sd_q;
    quo_d   = quo_q;
    steps_d = steps_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    ge      = rem_q >= RW'(sd_q);
    if (req_i.start) begin
      rem_d   = RW'(req_i.dividend);
      sd_d    = SD_W'(req_i.divisor) << (QW - 1);
      quo_d   = '0;
      steps_d = STW'(QW);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - RW'(sd_q);
      end
      quo_d   = (quo_q << 1) | QW'(ge);
      sd_d    = sd_q >> 1;
      steps_d = steps_q - STW'(1);
      if (steps_q == STW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sd_q  <= sd_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/fixed_slot_pool_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed slot pool allocator
// Pool of equally sized slots; free slot indices sit on a LIFO stack held in
// a synchronous RAM. Operations: init, alloc (pop), free (push).
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Payload
//  -------  ---  -------------  -----------------------------------------
//  req      in   valid/ready    func, free_offset
//  rsp      out  valid/ready    status, slot_offset, slot_index
//  cfg      in   cfg_we_i only  cfg_idx_i, cfg_data_i (slot size, count)
//
//  Steps: init forms the bound (S_LIMIT); alloc reads the stack (S_READ),
//  then multiplies (S_MUL); rejected alloc or free goes to S_DONE; accepted
//  free waits in S_DIV on the bit-serial divider (byte offset to slot index).
//  Reset: the stack is empty and no pool exists; no clearing pass is run.
//  Init writes no RAM: entries below the lowest stack top reached since init
//  still hold their init value and are generated, not read.
//  Stalls: one transaction at a time; a finished response parks in the
//  output register while the next request is taken.
//
module fixed_slot_pool_allocator_unit #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fspa_req_if.sink                      req,
  fspa_rsp_if.source                    rsp,
  input  logic                          cfg_we_i,
  input  logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fspa_pkg::*;

  // Count/top width, RAM address width, limit, compare, extension and product widths
  localparam int unsigned CW   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned LW   = CW + SIZE_W;
  localparam int unsigned CMPW = (LW > OFF_W) ? LW : OFF_W;
  localparam int unsigned EW   = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned XW   = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned PW   = IDX_W + SIZE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_LIMIT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // Configuration registers
  logic [SIZE_RAW_W-1:0] slot_size_raw_q;
  logic [CNT_CFG_W-1:0]  slot_count_q;

  // Control state
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] top_q, top_d;
  logic [CW-1:0] min_top_q, min_top_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [LW-1:0] limit_q, limit_d;
  logic          out_valid_q, out_valid_d;

  // Payload holding registers
  logic             hit_init_q, hit_init_d;
  logic [IDX_W-1:0] init_val_q, init_val_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  status_e          res_status_q, res_status_d;
  logic [SLOT_OFF_W-1:0] res_off_q, res_off_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  status_e          out_status_q;
  logic [SLOT_OFF_W-1:0] out_off_q;
  logic [IDX_W-1:0] out_idx_q;

  // Datapath
  logic             accept;
  logic             out_load;
  logic [SIZE_W-1:0] size_sum;
  logic [SIZE_W-1:0] size_new;
  logic [CW-1:0]    cnt_new;
  logic [CW-1:0]    pop_ptr;
  logic [EW-1:0]    init_val_ext;
  logic [PW-1:0]    alloc_prod;
  logic [XW-1:0]    quot_ext;

  // RAM and divider hookup
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  logic [IDX_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_rdata;
  div_req_t         div_req;
  logic             div_done;
  logic [AW-1:0]    div_quot;

  assign req.ready = (state_q == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

  // Round the requested size up to a multiple of eight, floor at eight
  assign size_sum = SIZE_W'(slot_size_raw_q) + SIZE_W'(SIZE_ROUND_ADD);
  assign size_new = (size_sum[SIZE_W-1:SIZE_ALIGN_LSB] == '0) ? SIZE_W'(MIN_SLOT_SIZE)
                  : {size_sum[SIZE_W-1:SIZE_ALIGN_LSB], SIZE_ALIGN_LSB'(0)};

  // Saturate the slot count to the stack depth
  assign cnt_new = (32'(slot_count_q) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS)
                                                         : CW'(slot_count_q);

  assign pop_ptr      = top_q - CW'(1);
  assign init_val_ext = EW'(cnt_q) - EW'(1) - EW'(pop_ptr);
  assign alloc_prod   = PW'(idx_q) * PW'(size_q);
  assign quot_ext     = XW'(div_quot);

  always_comb begin
    state_d      = state_q;
    top_d        = top_q;
    min_top_d    = min_top_q;
    cnt_d        = cnt_q;
    size_d       = size_q;
    limit_d      = limit_q;
    hit_init_d   = hit_init_q;
    init_val_d   = init_val_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    res_idx_d    = res_idx_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = top_q[AW-1:0];
    mem_raddr    = pop_ptr[AW-1:0];
    mem_wdata    = quot_ext[IDX_W-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = req.free_offset;
    div_req.divisor  = size_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req.func)
            FN_INIT: begin
              // Latch geometry; the stack reads as full of init values
              size_d       = size_new;
              cnt_d        = cnt_new;
              top_d        = cnt_new;
              min_top_d    = cnt_new;
              res_status_d = ST_INIT;
              res_off_d    = '0;
              res_idx_d    = '0;
              state_d      = S_LIMIT;
            end
            FN_ALLOC: begin
              res_off_d = '0;
              res_idx_d = '0;
              if (top_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_DONE;
              end else begin
                // Pop: issue the read, note whether the entry is untouched
                mem_re     = 1'b1;
                top_d      = pop_ptr;
                hit_init_d = pop_ptr < min_top_q;
                init_val_d = init_val_ext[IDX_W-1:0];
                if (pop_ptr < min_top_q) begin
                  min_top_d = pop_ptr;
                end
                state_d = S_READ;
              end
            end
            FN_FREE: begin
              res_off_d = '0;
              res_idx_d = '0;
              if (CMPW'(req.free_offset) >= CMPW'(limit_q)) begin
                res_status_d = ST_OOB;
                state_d      = S_DONE;
              end else if (top_q >= cnt_q) begin
                res_status_d = ST_FULL;
                state_d      = S_DONE;
              end else begin
                div_req.start = 1'b1;
                state_d       = S_DIV;
              end
            end
            default: begin
              // Unused code: drop the transaction, no response
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        idx_d   = hit_init_q ? init_val_q : mem_rdata;
        state_d = S_MUL;
      end
      S_MUL: begin
        res_status_d = ST_ALLOC;
        res_off_d    = alloc_prod[SLOT_OFF_W-1:0];
        res_idx_d    = idx_q;
        state_d      = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          // Push the slot index
          mem_we       = 1'b1;
          top_d        = top_q + CW'(1);
          res_status_d = ST_FREED;
          res_idx_d    = quot_ext[IDX_W-1:0];
          state_d      = S_DONE;
        end
      end
      S_LIMIT: begin
        limit_d = LW'(cnt_q) * LW'(size_q);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_size_raw_q <= SIZE_RAW_W'(SLOT_SIZE_RST);
      slot_count_q    <= CNT_CFG_W'(SLOT_COUNT_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLOT_SIZE:  slot_size_raw_q <= cfg_data_i[SIZE_RAW_W-1:0];
        CFG_SLOT_COUNT: slot_count_q    <= cfg_data_i[CNT_CFG_W-1:0];
        default: begin
          slot_count_q <= slot_count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      min_top_q   <= '0;
      cnt_q       <= '0;
      size_q      <= SIZE_W'(MIN_SLOT_SIZE);
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      min_top_q   <= min_top_d;
      cnt_q       <= cnt_d;
      size_q      <= size_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_init_q   <= hit_init_d;
    init_val_q   <= init_val_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    res_idx_q    <= res_idx_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_off_q    <= res_off_q;
      out_idx_q    <= res_idx_q;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_status_q;
  assign rsp.slot_offset = out_off_q;
  assign rsp.slot_index  = out_idx_q;

  fspa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fspa_div #(
    .QW (AW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

endmodule

// ===== bench/fixed_slot_pool_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed slot pool allocator testbench
// Drives init, alloc and free requests through the valid/ready request
// channel, predicts every response from an in-bench copy of the free-list
// stack and compares responses field by field. Slot size and count are
// reprogrammed between phases while the allocator is idle; both channels
// stall at random.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator_unit_tb;
  import fspa_pkg::*;

  localparam int unsigned POOL_DEPTH = 1024;
  // Function code with no operation behind it: the allocator drops it
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  // Cycles to let pass before touching registers, covering the slowest free
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_WAIT = 12;
  localparam int unsigned MAX_PRINTED = 30;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [OFF_W-1:0]  offset;
  } pool_req_t;

  typedef struct packed {
    status_e               status;
    logic [SLOT_OFF_W-1:0] slot_offset;
    logic [IDX_W-1:0]      slot_index;
  } pool_rsp_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fspa_req_if req_ch ();
  fspa_rsp_if rsp_ch ();

  fixed_slot_pool_allocator_unit #(
    .MAX_SLOTS(POOL_DEPTH)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Requests waiting to be driven, and responses predicted but not yet seen
  pool_req_t req_backlog_q[$];
  pool_rsp_t pool_results_q[$];

  // Register copies, as last written
  logic [SIZE_RAW_W-1:0] cfg_size_raw = SIZE_RAW_W'(SLOT_SIZE_RST);
  logic [CNT_CFG_W-1:0]  cfg_count    = CNT_CFG_W'(SLOT_COUNT_RST);

  // Predicted pool state: free-index stack, its top, slot size, latched count
  logic [IDX_W-1:0]     pool_stack [POOL_DEPTH];
  logic [CNT_CFG_W-1:0] pool_top   = '0;
  logic [SIZE_W-1:0]    pool_size  = SIZE_W'(SLOT_SIZE_RST);
  logic [CNT_CFG_W-1:0] pool_count = '0;

  // Idle shaping: a calm side never waits
  bit          req_calm;
  bit          rsp_calm;
  int unsigned req_gap;
  int unsigned rsp_stall;
  int unsigned rsp_hold;
  pool_req_t   drv_item;

  int unsigned fail_count;
  int unsigned reqs_taken;
  int unsigned rsps_seen;
  int unsigned reg_writes;
  int unsigned status_seen [6];

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic flag_mismatch(string what);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Apply one accepted request to the predicted pool and queue its response
  task automatic pool_apply(pool_req_t item);
    pool_rsp_t             res;
    logic [SIZE_W-1:0]     sz;
    logic [CNT_CFG_W-1:0]  cnt;
    logic [IDX_W-1:0]      idx;
    logic [63:0]           limit;
    logic [OFF_W-1:0]      quot;
    res = '{status: ST_INIT, slot_offset: '0, slot_index: '0};
    case (item.func)
      FN_INIT: begin
        // Round up to a multiple of eight, floor at eight, saturate the count
        sz = ((SIZE_W'(cfg_size_raw) + SIZE_W'(SIZE_ROUND_ADD)) >> SIZE_ALIGN_LSB)
             << SIZE_ALIGN_LSB;
        if (sz < SIZE_W'(MIN_SLOT_SIZE)) sz = SIZE_W'(MIN_SLOT_SIZE);
        cnt = (cfg_count > CNT_CFG_W'(POOL_DEPTH)) ? CNT_CFG_W'(POOL_DEPTH) : cfg_count;
        // Fill in reverse so that slot 0 sits on top
        for (int i = 0; i < int'(cnt); i++) pool_stack[i] = IDX_W'(int'(cnt) - 1 - i);
        pool_top   = cnt;
        pool_size  = sz;
        pool_count = cnt;
      end
      FN_ALLOC: begin
        if (pool_top == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pool_top--;
          idx = pool_stack[pool_top[IDX_W-1:0]];
          res.status      = ST_ALLOC;
          res.slot_offset = SLOT_OFF_W'(64'(idx) * 64'(pool_size));
          res.slot_index  = idx;
        end
      end
      FN_FREE: begin
        limit = 64'(pool_count) * 64'(pool_size);
        // Bounds take precedence over a full stack
        if (64'(item.offset) >= limit) begin
          res.status = ST_OOB;
        end else if (pool_top >= pool_count) begin
          res.status = ST_FULL;
        end else begin
          quot = item.offset / OFF_W'(pool_size);
          pool_stack[pool_top[IDX_W-1:0]] = quot[IDX_W-1:0];
          pool_top++;
          res.status     = ST_FREED;
          res.slot_index = quot[IDX_W-1:0];
        end
      end
      default: return;
    endcase
    pool_results_q.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Request driver: present the backlog one transaction at a time, with a
  // freshly drawn gap after each, and predict at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid       <= 1'b0;
      req_ch.func        <= FN_INIT;
      req_ch.free_offset <= '0;
      req_gap            <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        drv_item.func   = req_ch.func;
        drv_item.offset = req_ch.free_offset;
        pool_apply(drv_item);
        reqs_taken++;
      end
      // Only move on once the current transaction has gone (or none is held)
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap != 0) begin
          req_ch.valid <= 1'b0;
          req_gap      <= req_gap - 1;
        end else if (req_backlog_q.size() != 0) begin
          drv_item           = req_backlog_q.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.func        <= drv_item.func;
          req_ch.free_offset <= drv_item.offset;
          req_gap            <= draw_wait(req_calm);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor: compare each transaction against the oldest prediction,
  // then hold ready low for a drawn number of cycles.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall    <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsps_seen++;
        if (rsp_ch.status <= ST_INIT) status_seen[rsp_ch.status]++;
        if (pool_results_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected response, status %0d", rsp_ch.status));
        end else begin
          automatic pool_rsp_t want = pool_results_q.pop_front();
          if (rsp_ch.status !== want.status)
            flag_mismatch($sformatf("status %0d, predicted %0d", rsp_ch.status, want.status));
          if (rsp_ch.slot_offset !== want.slot_offset)
            flag_mismatch($sformatf("slot_offset %0d, predicted %0d", rsp_ch.slot_offset,
                                    want.slot_offset));
          if (rsp_ch.slot_index !== want.slot_index)
            flag_mismatch($sformatf("slot_index %0d, predicted %0d", rsp_ch.slot_index,
                                    want.slot_index));
        end
        rsp_hold      = draw_wait(rsp_calm);
        rsp_stall    <= rsp_hold;
        rsp_ch.ready <= (rsp_hold == 0);
      end else if (rsp_stall != 0) begin
        rsp_stall    <= rsp_stall - 1;
        rsp_ch.ready <= (rsp_stall == 1);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_req(logic [FUNC_W-1:0] func, logic [OFF_W-1:0] offset);
    req_backlog_q.push_back('{func: func, offset: offset});
  endtask

  // Hold until the backlog is empty and every prediction has been matched,
  // then let a trailing ignored code, which has no response, clear through.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (req_backlog_q.size() != 0 || req_ch.valid || pool_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the selected registers on consecutive edges; the allocator is idle
  task automatic set_pool(logic [CFG_DATA_W-1:0] size_raw, logic [CFG_DATA_W-1:0] count_raw,
                          bit wr_size, bit wr_count);
    if (wr_size) begin
      @(posedge clk_i);
      cfg_we_i     <= 1'b1;
      cfg_idx_i    <= CFG_SLOT_SIZE;
      cfg_data_i   <= size_raw;
      cfg_size_raw  = size_raw[SIZE_RAW_W-1:0];
      reg_writes++;
    end
    if (wr_count) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_SLOT_COUNT;
      cfg_data_i <= count_raw;
      cfg_count   = count_raw[CNT_CFG_W-1:0];
      reg_writes++;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random phase: new settings, an init, then a mix dominated by allocs
  // and in-range frees, with stray offsets, re-inits and dead codes mixed in.
  task automatic random_phase(int unsigned n_items);
    logic [CFG_DATA_W-1:0] size_raw;
    logic [CFG_DATA_W-1:0] count_raw;
    int unsigned           pick;
    int unsigned           gen_size;
    int unsigned           gen_count;
    int unsigned           mask;
    int unsigned           done;
    logic [OFF_W-1:0]      offs;
    req_calm = ($urandom_range(0, 3) == 0);
    rsp_calm = ($urandom_range(0, 3) == 0);
    size_raw  = CFG_DATA_W'(cfg_size_raw);
    count_raw = CFG_DATA_W'(cfg_count);
    case ($urandom_range(0, 3))
      0: size_raw = CFG_DATA_W'($urandom_range(0, 16));
      1: size_raw = CFG_DATA_W'($urandom_range(0, 65535));
      2: size_raw = 16'hFFFF;
      default: size_raw = CFG_DATA_W'($urandom_range(1, 200));
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 4)       count_raw = CFG_DATA_W'($urandom_range(1, 12));
    else if (pick < 6)  count_raw = CFG_DATA_W'($urandom_range(13, 64));
    else if (pick == 6) count_raw = CFG_DATA_W'(POOL_DEPTH);
    else if (pick == 7) count_raw = CFG_DATA_W'($urandom_range(POOL_DEPTH + 1, 2047));
    else if (pick == 8) count_raw = '0;
    else                count_raw = CFG_DATA_W'($urandom_range(0, 65535));
    // Usually both registers; now and then only one of them
    mask = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 3;
    set_pool(size_raw, count_raw, mask[0], mask[1]);

    gen_size = ((int'(cfg_size_raw) + SIZE_ROUND_ADD) >> SIZE_ALIGN_LSB) << SIZE_ALIGN_LSB;
    if (gen_size < MIN_SLOT_SIZE) gen_size = MIN_SLOT_SIZE;
    gen_count = (cfg_count > POOL_DEPTH) ? POOL_DEPTH : cfg_count;

    queue_req(FN_INIT, $urandom);
    done = 0;
    while (done < n_items) begin
      // Pause the sender halfway until the allocator has fully drained
      if (done == n_items / 2) begin
        wait_idle();
        done++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_req(FN_ALLOC, $urandom);
      end else if (pick < 85 && gen_count != 0) begin
        offs = $urandom_range(0, gen_count - 1) * gen_size + $urandom_range(0, gen_size - 1);
        queue_req(FN_FREE, offs);
      end else if (pick < 92) begin
        queue_req(FN_FREE, $urandom);
      end else if (pick < 95) begin
        queue_req(FN_FREE, gen_count * gen_size + $urandom_range(0, 2 * gen_size));
      end else if (pick < 98) begin
        queue_req(FN_INIT, $urandom);
      end else begin
        // Ignored by the allocator: does not count toward the phase
        queue_req(FN_UNUSED, $urandom);
        continue;
      end
      done++;
    end
    wait_idle();
  endtask

  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_SLOT_SIZE;
    cfg_data_i <= '0;
    req_calm    = 1'b0;
    rsp_calm    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // No pool yet: alloc is empty, any free is out of bounds, dead code dropped
    queue_req(FN_ALLOC, '0);
    queue_req(FN_FREE, '0);
    queue_req(FN_UNUSED, '1);
    wait_idle();

    // Zero size rounds to the minimum of eight; four slots, drain and overfill
    set_pool(16'd0, 16'd4, 1'b1, 1'b1);
    queue_req(FN_INIT, '0);
    repeat (4) queue_req(FN_ALLOC, '0);
    queue_req(FN_ALLOC, '1);
    queue_req(FN_FREE, 32'd8);
    queue_req(FN_FREE, 32'd15);
    queue_req(FN_FREE, 32'd31);
    queue_req(FN_FREE, 32'd32);
    queue_req(FN_FREE, 32'd0);
    queue_req(FN_FREE, 32'd24);
    queue_req(FN_FREE, 32'hFFFF_FFFF);
    queue_req(FN_UNUSED, '0);
    wait_idle();

    // Largest size and an oversized count that saturates to the stack depth
    set_pool(16'hFFFF, 16'd2047, 1'b1, 1'b1);
    queue_req(FN_INIT, '1);
    queue_req(FN_ALLOC, '0);
    queue_req(FN_FREE, 32'd67108863);
    queue_req(FN_ALLOC, '0);
    queue_req(FN_FREE, 32'd67108864);
    wait_idle();

    // Zero slots: nothing to allocate, nothing in bounds
    set_pool(16'd13, 16'd0, 1'b1, 1'b1);
    queue_req(FN_INIT, '0);
    queue_req(FN_ALLOC, '0);
    queue_req(FN_FREE, '0);
    wait_idle();

    repeat (8) random_phase(48);

    $display("Ran %0d requests and %0d responses over %0d register writes.",
             reqs_taken, rsps_seen, reg_writes);
    $display("Responses: alloc %0d, empty %0d, freed %0d, out of bounds %0d, full %0d, init %0d.",
             status_seen[ST_ALLOC], status_seen[ST_EMPTY], status_seen[ST_FREED],
             status_seen[ST_OOB], status_seen[ST_FULL], status_seen[ST_INIT]);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fspa_pkg.sv
rtl/fspa_if.sv
rtl/fspa_ram.sv
rtl/fspa_div.sv
rtl/fixed_slot_pool_allocator_unit.sv
bench/fixed_slot_pool_allocator_unit_tb.sv
